@@ hw/rtl/cardinal_spline_tessellator_unit_assert.svh @@
// Assertion macros for the cardinal spline tessellator.
// Both macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef CARDINAL_SPLINE_TESSELLATOR_UNIT_ASSERT_SVH
`define CARDINAL_SPLINE_TESSELLATOR_UNIT_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define CSTU_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("cstu assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define CSTU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cstu assertion failed");

`endif

@@ hw/rtl/csplt_pkg.sv @@
// Shared types and constants for the cardinal spline tessellator.
// No dependencies; used by the controller, datapath, lane and top level.
`timescale 1ns / 1ps
`default_nettype none
package csplt_pkg;

    localparam int CW       = 24;       // coordinate width
    localparam int TW       = 16;       // tension width, Q1.15
    localparam int NW       = 6;        // step count width
    localparam int MW       = 18;       // width of the step count cubed
    localparam int AW       = 66;       // accumulator width
    localparam int SPW      = CW + TW + 1;
    localparam int TSH      = 15;       // tension one is 2^15
    localparam int DIV_LAST = CW - 1;

    localparam logic [NW-1:0] STEPS_RESET   = NW'(16);
    localparam logic [TW-1:0] TENSION_RESET = TW'(16384);
    localparam logic [NW-1:0] STEPS_MAX     = NW'(62);

    // Configuration register indexes
    localparam logic [1:0] CFG_STEPS   = 2'd0;
    localparam logic [1:0] CFG_TENSION = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_COEF,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_INIT,
        S_ROUND,
        S_PREP,
        S_DIV,
        S_EMIT,
        S_EMIT_CTL
    } t_state;

    typedef struct packed {
        logic take;
        logic scale;
        logic coef;
        logic mul1;
        logic mul2;
        logic mul3;
        logic init;
        logic round;
        logic prep;
        logic div;
        logic load_vtx;
        logic load_ctl;
        logic adv;
        logic shift;
    } t_cmd;

    typedef struct packed {
        logic          seg_start;
        logic          out_free;
        logic [NW-1:0] steps;
    } t_sts;

endpackage
`default_nettype wire

@@ hw/rtl/cardinal_spline_tessellator_unit.sv @@
// Sequence: a point that completes a segment runs the setup states (scale, coef, mul1,
// mul2, mul3, init) after it is accepted, then per vertex round, range check, 24-step
// restoring divide and output, then the end point; output stalls hold the emit states.
// No new point is taken until the segment ends; a window-filling point is taken in idle.
// Reset: synchronous active-low; clears the state, the window count and the output valid,
// and loads 16 steps and tension 0.5.
`timescale 1ns / 1ps
`default_nettype none
`include "cardinal_spline_tessellator_unit_assert.svh"
module cardinal_spline_tessellator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // point_x [23:0], point_y [47:24], point_z [71:48]
    input  logic [0:0]  i_s_tuser,   // new_curve [0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // vertex_x [23:0], vertex_y [47:24], vertex_z [71:48]
    output logic [1:0]  o_m_tuser,   // is_control_point [0], saturated [1]
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import csplt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic signed [CW-1:0] vx, vy, vz;
    logic ctl, sat;

    csplt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_sts      (sts),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    csplt_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_point_x          (i_s_tdata[23:0]),
        .i_point_y          (i_s_tdata[47:24]),
        .i_point_z          (i_s_tdata[71:48]),
        .i_new_curve        (i_s_tuser[0]),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_cfg_ready        (o_cfg_ready),
        .i_out_ready        (i_m_tready),
        .o_out_valid        (o_m_tvalid),
        .o_vertex_x         (vx),
        .o_vertex_y         (vy),
        .o_vertex_z         (vz),
        .o_is_control_point (ctl),
        .o_saturated        (sat),
        .o_last             (o_m_tlast)
    );

    assign o_m_tdata = {vz, vy, vx};
    assign o_m_tuser = {sat, ctl};

    // The end point word, and only it, closes a segment
    `CSTU_ASSERT_ALWAYS(a_last_is_ctl, !o_m_tvalid || (o_m_tuser[0] == o_m_tlast))
    // The end point copy is never clipped
    `CSTU_ASSERT_ALWAYS(a_ctl_not_sat, !(o_m_tvalid && o_m_tuser[0] && o_m_tuser[1]))
    // A new point is never taken while a segment still has vertices pending
    `CSTU_ASSERT_ALWAYS(a_idle_no_vtx, !(o_s_tready && o_m_tvalid && !o_m_tlast))
    // Starting a segment takes the block out of the idle state
    `CSTU_ASSERT_NEXT(a_seg_busy, o_s_tready && i_s_tvalid && sts.seg_start, !o_s_tready)

endmodule
`default_nettype wire

@@ hw/rtl/csplt_ctrl.sv @@
// Sequencing state machine for the tessellator.
// Depends on csplt_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none
module csplt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  csplt_pkg::t_sts  i_sts,
    output logic             o_in_ready,
    output csplt_pkg::t_cmd  o_cmd
);
    import csplt_pkg::*;

    t_state r_state, n_state;
    logic [NW-1:0] r_j;
    logic [4:0]    r_cnt;
    logic          seg_done;

    assign seg_done = (r_j == i_sts.steps);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid && i_sts.seg_start) n_state = S_SCALE;
            S_SCALE:    n_state = S_COEF;
            S_COEF:     n_state = S_MUL1;
            S_MUL1:     n_state = S_MUL2;
            S_MUL2:     n_state = S_MUL3;
            S_MUL3:     n_state = S_INIT;
            S_INIT:     n_state = S_ROUND;
            S_ROUND:    n_state = S_PREP;
            S_PREP:     n_state = S_DIV;
            S_DIV:      if (r_cnt == 5'(DIV_LAST)) n_state = S_EMIT;
            S_EMIT:     if (i_sts.out_free) n_state = seg_done ? S_EMIT_CTL : S_ROUND;
            S_EMIT_CTL: if (i_sts.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_SCALE: o_cmd.scale = 1'b1;
            S_COEF:  o_cmd.coef  = 1'b1;
            S_MUL1:  o_cmd.mul1  = 1'b1;
            S_MUL2:  o_cmd.mul2  = 1'b1;
            S_MUL3:  o_cmd.mul3  = 1'b1;
            S_INIT:  o_cmd.init  = 1'b1;
            S_ROUND: o_cmd.round = 1'b1;
            S_PREP:  o_cmd.prep  = 1'b1;
            S_DIV:   o_cmd.div   = 1'b1;
            S_EMIT: begin
                o_cmd.load_vtx = i_sts.out_free;
                o_cmd.adv      = i_sts.out_free && !seg_done;
            end
            S_EMIT_CTL: begin
                o_cmd.load_ctl = i_sts.out_free;
                o_cmd.shift    = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // State, vertex index and divide step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) r_j <= '0;
            else if (r_state == S_EMIT && i_sts.out_free) r_j <= r_j + 1'b1;
            if (r_state == S_PREP) r_cnt <= '0;
            else if (r_state == S_DIV) r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/csplt_lane.sv @@
// One coordinate lane: cubic setup, forward differencing and rounding divide.
// Depends on csplt_pkg for widths and the command type.
`timescale 1ns / 1ps
`default_nettype none
module csplt_lane (
    input  logic                                 i_clk,
    input  csplt_pkg::t_cmd                      i_cmd,
    input  logic signed [csplt_pkg::CW-1:0]      i_p0,
    input  logic signed [csplt_pkg::CW-1:0]      i_p1,
    input  logic signed [csplt_pkg::CW-1:0]      i_p2,
    input  logic signed [csplt_pkg::CW-1:0]      i_p3,
    input  logic        [csplt_pkg::TW-1:0]      i_s,
    input  logic        [csplt_pkg::NW-1:0]      i_n,
    input  logic        [csplt_pkg::MW-1:0]      i_m,
    output logic signed [csplt_pkg::CW-1:0]      o_vertex,
    output logic                                 o_sat
);
    import csplt_pkg::*;

    logic signed [SPW-1:0] r_sp0, r_sp1, r_sp2, r_sp3;
    logic signed [AW-1:0]  r_a, r_b, r_c, r_e;
    logic signed [AW-1:0]  r_bn, r_cn, r_en;
    logic signed [AW-1:0]  r_v, r_d1, r_d2, r_d3, r_y;
    logic [MW-1:0]         r_rem;
    logic [CW-1:0]         r_quo;
    logic                  r_sat_hi, r_sat_lo;

    logic signed [TW:0]    s_sg;
    logic signed [NW:0]    n_sg;
    logic signed [AW-1:0]  sp0, sp1, sp2, sp3, p1e, p2e, mw, lim, yo, a6;
    logic signed [AW-1:0]  c_a, c_b, c_c, c_e;
    logic signed [AW-1:0]  bn, cn, en;
    logic [MW:0]           sh, diff;

    assign s_sg = $signed({1'b0, i_s});
    assign n_sg = $signed({1'b0, i_n});
    assign sp0  = AW'(r_sp0);
    assign sp1  = AW'(r_sp1);
    assign sp2  = AW'(r_sp2);
    assign sp3  = AW'(r_sp3);
    assign p1e  = AW'(i_p1);
    assign p2e  = AW'(i_p2);
    assign mw   = $signed(AW'(i_m));
    assign lim  = mw <<< (CW - 1);
    assign yo   = r_y + lim;
    assign a6   = (r_a <<< 2) + (r_a <<< 1);

    // Cubic coefficients of the weighted sum in u, scaled by n powers later
    assign c_a = -sp0 - sp1 + sp2 + sp3 + (p1e <<< (TSH + 1)) - (p2e <<< (TSH + 1));
    assign c_b = (sp0 <<< 1) + sp1 - (sp2 <<< 1) - sp3
                 - ((p1e <<< (TSH + 1)) + (p1e <<< TSH))
                 + ((p2e <<< (TSH + 1)) + (p2e <<< TSH));
    assign c_c = sp2 - sp0;
    assign c_e = p1e <<< TSH;

    // Multiplications by the step count
    assign bn = r_b * AW'(n_sg);
    assign cn = r_cn * AW'(n_sg);
    assign en = r_en * AW'(n_sg);

    // One restoring divide step
    assign sh   = {r_rem, r_quo[CW-1]};
    assign diff = sh - {1'b0, i_m};

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_sp0 <= SPW'(s_sg) * SPW'(i_p0);
            r_sp1 <= SPW'(s_sg) * SPW'(i_p1);
            r_sp2 <= SPW'(s_sg) * SPW'(i_p2);
            r_sp3 <= SPW'(s_sg) * SPW'(i_p3);
        end
        if (i_cmd.coef) begin
            r_a  <= c_a;
            r_b  <= c_b;
            r_cn <= c_c;
            r_en <= c_e;
        end
        if (i_cmd.mul1) begin
            r_bn <= bn;
            r_c  <= cn;
            r_e  <= en;
        end
        if (i_cmd.mul2) begin
            r_cn <= r_c * AW'(n_sg);
            r_en <= r_e * AW'(n_sg);
        end
        if (i_cmd.mul3) begin
            r_e <= r_en * AW'(n_sg);
        end
        // Forward differences start at u = 0
        if (i_cmd.init) begin
            r_v  <= r_e;
            r_d1 <= r_a + r_bn + r_cn;
            r_d2 <= a6 + (r_bn <<< 1);
            r_d3 <= a6;
        end
        if (i_cmd.adv) begin
            r_v  <= r_v + r_d1;
            r_d1 <= r_d1 + r_d2;
            r_d2 <= r_d2 + r_d3;
        end
        // Add half the divisor and drop the power-of-two part of it
        if (i_cmd.round) begin
            r_y <= (r_v + (mw <<< (TSH - 1))) >>> TSH;
        end
        // Range check and offset so the quotient is never negative
        if (i_cmd.prep) begin
            r_sat_hi <= (r_y >= lim);
            r_sat_lo <= (r_y < -lim);
            r_rem    <= yo[MW+CW-1:CW];
            r_quo    <= yo[CW-1:0];
        end
        if (i_cmd.div) begin
            if (!diff[MW]) begin
                r_rem <= diff[MW-1:0];
                r_quo <= {r_quo[CW-2:0], 1'b1};
            end else begin
                r_rem <= sh[MW-1:0];
                r_quo <= {r_quo[CW-2:0], 1'b0};
            end
        end
    end

    // Remove the offset by flipping the top bit, or clip
    always_comb begin
        o_sat = r_sat_hi || r_sat_lo;
        if (r_sat_hi) o_vertex = {1'b0, {(CW-1){1'b1}}};
        else if (r_sat_lo) o_vertex = {1'b1, {(CW-1){1'b0}}};
        else o_vertex = {~r_quo[CW-1], r_quo[CW-2:0]};
    end

endmodule
`default_nettype wire

@@ hw/rtl/csplt_dp.sv @@
// Datapath: configuration, point window, three coordinate lanes, output word.
// Depends on csplt_pkg and csplt_lane.
`timescale 1ns / 1ps
`default_nettype none
module csplt_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  csplt_pkg::t_cmd                  i_cmd,
    output csplt_pkg::t_sts                  o_sts,
    input  logic signed [csplt_pkg::CW-1:0]  i_point_x,
    input  logic signed [csplt_pkg::CW-1:0]  i_point_y,
    input  logic signed [csplt_pkg::CW-1:0]  i_point_z,
    input  logic                             i_new_curve,
    input  logic                             i_cfg_valid,
    input  logic [1:0]                       i_cfg_index,
    input  logic [csplt_pkg::TW-1:0]         i_cfg_data,
    output logic                             o_cfg_ready,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic signed [csplt_pkg::CW-1:0]  o_vertex_x,
    output logic signed [csplt_pkg::CW-1:0]  o_vertex_y,
    output logic signed [csplt_pkg::CW-1:0]  o_vertex_z,
    output logic                             o_is_control_point,
    output logic                             o_saturated,
    output logic                             o_last
);
    import csplt_pkg::*;

    logic [NW-1:0]          r_steps;
    logic [TW-1:0]          r_tension;
    logic [1:0]             r_held;
    logic signed [CW-1:0]   r_win [3][3];
    logic signed [CW-1:0]   r_np [3];
    logic [2*NW-1:0]        r_n2;
    logic [MW-1:0]          r_m;
    logic                   r_ov;
    logic signed [CW-1:0]   r_vx, r_vy, r_vz;
    logic                   r_ctl, r_sat, r_last;

    logic [1:0]             held_eff;
    logic [NW-1:0]          n_eff;
    logic signed [CW-1:0]   pt [3];
    logic signed [CW-1:0]   lane_v [3];
    logic [2:0]             lane_sat;
    logic [2*NW-1:0]        n_sq;
    logic [2*NW+NW-1:0]     n_cu;

    assign o_cfg_ready = 1'b1;
    assign held_eff    = i_new_curve ? 2'd0 : r_held;
    assign pt[0]       = i_point_x;
    assign pt[1]       = i_point_y;
    assign pt[2]       = i_point_z;
    assign n_sq        = (2*NW)'(n_eff) * (2*NW)'(n_eff);
    assign n_cu        = (3*NW)'(r_n2) * (3*NW)'(n_eff);

    // Step count limited to the supported range
    always_comb begin
        if (r_steps == '0) n_eff = NW'(1);
        else if (r_steps > STEPS_MAX) n_eff = STEPS_MAX;
        else n_eff = r_steps;
    end

    assign o_sts.seg_start = (held_eff == 2'd3);
    assign o_sts.out_free  = !r_ov || i_out_ready;
    assign o_sts.steps     = n_eff;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps   <= STEPS_RESET;
            r_tension <= TENSION_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEPS:   r_steps   <= i_cfg_data[NW-1:0];
                CFG_TENSION: r_tension <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Fill count of the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.take && held_eff != 2'd3) begin
            r_held <= held_eff + 2'd1;
        end
    end

    // Point window, newest point and step count powers
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.take) begin
                if (held_eff == 2'd3) r_np[c] <= pt[c];
                else r_win[held_eff][c] <= pt[c];
            end else if (i_cmd.shift) begin
                r_win[0][c] <= r_win[1][c];
                r_win[1][c] <= r_win[2][c];
                r_win[2][c] <= r_np[c];
            end
        end
        if (i_cmd.mul1) r_n2 <= n_sq;
        if (i_cmd.mul2) r_m  <= n_cu[MW-1:0];
    end

    // One lane per coordinate
    for (genvar c = 0; c < 3; c++) begin : g_lane
        csplt_lane u_lane (
            .i_clk    (i_clk),
            .i_cmd    (i_cmd),
            .i_p0     (r_win[0][c]),
            .i_p1     (r_win[1][c]),
            .i_p2     (r_win[2][c]),
            .i_p3     (r_np[c]),
            .i_s      (r_tension),
            .i_n      (n_eff),
            .i_m      (r_m),
            .o_vertex (lane_v[c]),
            .o_sat    (lane_sat[c])
        );
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_vtx || i_cmd.load_ctl) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vtx) begin
            r_vx   <= lane_v[0];
            r_vy   <= lane_v[1];
            r_vz   <= lane_v[2];
            r_ctl  <= 1'b0;
            r_sat  <= |lane_sat;
            r_last <= 1'b0;
        end else if (i_cmd.load_ctl) begin
            r_vx   <= r_win[2][0];
            r_vy   <= r_win[2][1];
            r_vz   <= r_win[2][2];
            r_ctl  <= 1'b1;
            r_sat  <= 1'b0;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid        = r_ov;
    assign o_vertex_x         = r_vx;
    assign o_vertex_y         = r_vy;
    assign o_vertex_z         = r_vz;
    assign o_is_control_point = r_ctl;
    assign o_saturated        = r_sat;
    assign o_last             = r_last;

endmodule
`default_nettype wire
